// ===== sv/lbax_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the light bar axis extraction block
// no dependencies
package lbax_pkg;

  localparam int DIR_SCALE_DEF  = 10;
  localparam int COORD_BITS_DEF = 16;
  localparam int LEN_W          = 17;
  localparam int UNIT_W         = 13;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

endpackage

// ===== sv/lbax_front.sv =====
`timescale 1ns / 1ps
// front pipeline: side pairing, midpoints, axis vector, squared terms
// depends on lbax_pkg
module lbax_front import lbax_pkg::*; #(
  parameter int C  = COORD_BITS_DEF,
  parameter int DS = DIR_SCALE_DEF,
  parameter int QB = 23,
  parameter int LW = 2 * C + 1,
  parameter int DW = LW + QB,
  parameter int PW = 6 * C + 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [C-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y,
  output logic                v_o,
  output logic [PW-1:0]       side_o,
  output logic [LW-1:0]       d2_o,
  output logic [DW-1:0]       nx_o,
  output logic [DW-1:0]       ny_o
);

  localparam logic [QB-1:0] S2V = QB'((DS * 256) * (DS * 256));

  function automatic logic [C-1:0] half(input logic [C-1:0] a, input logic [C-1:0] b);
    logic [C:0] s;
    s = {a[C-1], a} + {b[C-1], b};
    return s[C:1];
  endfunction

  function automatic logic [2*C-1:0] sqd(input logic [C-1:0] a, input logic [C-1:0] b);
    logic signed [C:0]     d;
    logic signed [2*C+1:0] p;
    d = $signed({a[C-1], a}) - $signed({b[C-1], b});
    p = d * d;
    return p[2*C-1:0];
  endfunction

  // stage 1: input register
  logic         s1_v_r;
  logic [C-1:0] s1_x_r [4];
  logic [C-1:0] s1_y_r [4];
  // stage 2: squared sides
  logic           s2_v_r;
  logic [C-1:0]   s2_x_r [4];
  logic [C-1:0]   s2_y_r [4];
  logic [2*C-1:0] s2_ax_r, s2_ay_r, s2_bx_r, s2_by_r;
  // stage 3: endpoints
  logic         s3_v_r;
  logic [C-1:0] s3_ax_r, s3_ay_r, s3_bx_r, s3_by_r;
  // stage 4: centre and axis vector
  logic         s4_v_r;
  logic [C-1:0] s4_ax_r, s4_ay_r, s4_bx_r, s4_by_r, s4_mx_r, s4_my_r;
  logic [C:0]   s4_dx_r, s4_dy_r;
  // stage 5: squared components
  logic           s5_v_r;
  logic [6*C-1:0] s5_pt_r;
  logic           s5_sx_r, s5_sy_r;
  logic [2*C-1:0] s5_qx_r, s5_qy_r;
  // stage 6: length squared and scaled partial products
  logic           s6_v_r;
  logic [PW-1:0]  s6_side_r;
  logic [LW-1:0]  s6_d2_r;
  logic [C+QB-1:0] s6_xl_r, s6_xh_r, s6_yl_r, s6_yh_r;

  logic [2*C:0] a2_nxt, b2_nxt;
  logic         pick_a;
  logic [C:0]   dx_nxt, dy_nxt;
  logic signed [2*C+1:0] qx_nxt, qy_nxt;

  always_comb begin
    a2_nxt = {1'b0, s2_ax_r} + {1'b0, s2_ay_r};
    b2_nxt = {1'b0, s2_bx_r} + {1'b0, s2_by_r};
    pick_a = a2_nxt >= b2_nxt;
    dx_nxt = {s3_bx_r[C-1], s3_bx_r} - {s3_ax_r[C-1], s3_ax_r};
    dy_nxt = {s3_by_r[C-1], s3_by_r} - {s3_ay_r[C-1], s3_ay_r};
    qx_nxt = $signed(s4_dx_r) * $signed(s4_dx_r);
    qy_nxt = $signed(s4_dy_r) * $signed(s4_dy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      v_o    <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      v_o    <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r[0] <= c0x; s1_y_r[0] <= c0y;
      s1_x_r[1] <= c1x; s1_y_r[1] <= c1y;
      s1_x_r[2] <= c2x; s1_y_r[2] <= c2y;
      s1_x_r[3] <= c3x; s1_y_r[3] <= c3y;

      s2_x_r  <= s1_x_r;
      s2_y_r  <= s1_y_r;
      s2_ax_r <= sqd(s1_x_r[0], s1_x_r[1]);
      s2_ay_r <= sqd(s1_y_r[0], s1_y_r[1]);
      s2_bx_r <= sqd(s1_x_r[1], s1_x_r[2]);
      s2_by_r <= sqd(s1_y_r[1], s1_y_r[2]);

      // tie takes the first pairing
      if (pick_a) begin
        s3_ax_r <= half(s2_x_r[1], s2_x_r[2]);
        s3_ay_r <= half(s2_y_r[1], s2_y_r[2]);
        s3_bx_r <= half(s2_x_r[3], s2_x_r[0]);
        s3_by_r <= half(s2_y_r[3], s2_y_r[0]);
      end else begin
        s3_ax_r <= half(s2_x_r[1], s2_x_r[0]);
        s3_ay_r <= half(s2_y_r[1], s2_y_r[0]);
        s3_bx_r <= half(s2_x_r[3], s2_x_r[2]);
        s3_by_r <= half(s2_y_r[3], s2_y_r[2]);
      end

      s4_ax_r <= s3_ax_r;
      s4_ay_r <= s3_ay_r;
      s4_bx_r <= s3_bx_r;
      s4_by_r <= s3_by_r;
      s4_mx_r <= half(s3_ax_r, s3_bx_r);
      s4_my_r <= half(s3_ay_r, s3_by_r);
      s4_dx_r <= dx_nxt;
      s4_dy_r <= dy_nxt;

      s5_pt_r <= {s4_my_r, s4_mx_r, s4_by_r, s4_bx_r, s4_ay_r, s4_ax_r};
      s5_sx_r <= s4_dx_r[C];
      s5_sy_r <= s4_dy_r[C];
      s5_qx_r <= qx_nxt[2*C-1:0];
      s5_qy_r <= qy_nxt[2*C-1:0];

      s6_side_r <= {(s5_qx_r == '0) && (s5_qy_r == '0), s5_sy_r, s5_sx_r, s5_pt_r};
      s6_d2_r   <= {1'b0, s5_qx_r} + {1'b0, s5_qy_r};
      s6_xl_r   <= (C+QB)'(s5_qx_r[C-1:0]) * (C+QB)'(S2V);
      s6_xh_r   <= (C+QB)'(s5_qx_r[2*C-1:C]) * (C+QB)'(S2V);
      s6_yl_r   <= (C+QB)'(s5_qy_r[C-1:0]) * (C+QB)'(S2V);
      s6_yh_r   <= (C+QB)'(s5_qy_r[2*C-1:C]) * (C+QB)'(S2V);

      side_o <= s6_side_r;
      d2_o   <= s6_d2_r;
      nx_o   <= (DW'(s6_xh_r) << C) + DW'(s6_xl_r);
      ny_o   <= (DW'(s6_yh_r) << C) + DW'(s6_yl_r);
    end
  end

endmodule

// ===== sv/lbax_div_cell.sv =====
`timescale 1ns / 1ps
// one quotient bit of both direction divides (when J < QB) and one bit of the length root (when J < LB)
// depends on lbax_pkg
module lbax_div_cell import lbax_pkg::*; #(
  parameter int QB = 23,
  parameter int LW = 33,
  parameter int LB = 17,
  parameter int DW = LW + QB,
  parameter int PW = 99,
  parameter int J  = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [PW-1:0] side_i,
  input  logic [LW-1:0] d2_i,
  input  logic [DW-1:0] rx_i, ry_i,
  input  logic [QB-1:0] qx_i, qy_i,
  input  logic [LW-1:0] lr_i,
  input  logic [LB-1:0] lres_i,
  output logic          v_o,
  output logic [PW-1:0] side_o,
  output logic [LW-1:0] d2_o,
  output logic [DW-1:0] rx_o, ry_o,
  output logic [QB-1:0] qx_o, qy_o,
  output logic [LW-1:0] lr_o,
  output logic [LB-1:0] lres_o
);

  localparam bit DACT = (J < QB);
  localparam bit SACT = (J < LB);

  logic [DW-1:0]   dtr;
  logic [LW+1:0]   str;
  logic [DW-1:0]   rx_nxt, ry_nxt;
  logic [QB-1:0]   qx_nxt, qy_nxt;
  logic [LW-1:0]   lr_nxt;
  logic [LB-1:0]   lres_nxt;

  always_comb begin
    dtr = DW'(d2_i) << J;
    // (res + 2^j)^2 - res^2 with res holding only the bits above j
    str = ((LW+2)'(lres_i) << (J + 1)) + ((LW+2)'(1) << (2 * J));
    rx_nxt = rx_i;
    ry_nxt = ry_i;
    qx_nxt = qx_i;
    qy_nxt = qy_i;
    lr_nxt = lr_i;
    lres_nxt = lres_i;
    if (DACT && rx_i >= dtr) begin
      rx_nxt = rx_i - dtr;
      qx_nxt = qx_i | (QB'(1) << J);
    end
    if (DACT && ry_i >= dtr) begin
      ry_nxt = ry_i - dtr;
      qy_nxt = qy_i | (QB'(1) << J);
    end
    if (SACT && {2'b00, lr_i} >= str) begin
      lr_nxt = LW'({2'b00, lr_i} - str);
      lres_nxt = lres_i | (LB'(1) << J);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      d2_o   <= d2_i;
      rx_o   <= rx_nxt;
      ry_o   <= ry_nxt;
      qx_o   <= qx_nxt;
      qy_o   <= qy_nxt;
      lr_o   <= lr_nxt;
      lres_o <= lres_nxt;
    end
  end

endmodule

// ===== sv/lbax_root_cell.sv =====
`timescale 1ns / 1ps
// one result bit of the square roots of both scaled direction terms
// depends on lbax_pkg
module lbax_root_cell import lbax_pkg::*; #(
  parameter int QB = 23,
  parameter int RB = 12,
  parameter int PW = 116,
  parameter int J  = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [PW-1:0] side_i,
  input  logic [QB-1:0] rx_i, ry_i,
  input  logic [RB-1:0] ux_i, uy_i,
  output logic          v_o,
  output logic [PW-1:0] side_o,
  output logic [QB-1:0] rx_o, ry_o,
  output logic [RB-1:0] ux_o, uy_o
);

  logic [QB+1:0] trx, try_;
  logic [QB-1:0] rx_nxt, ry_nxt;
  logic [RB-1:0] ux_nxt, uy_nxt;

  always_comb begin
    trx  = ((QB+2)'(ux_i) << (J + 1)) + ((QB+2)'(1) << (2 * J));
    try_ = ((QB+2)'(uy_i) << (J + 1)) + ((QB+2)'(1) << (2 * J));
    rx_nxt = rx_i;
    ry_nxt = ry_i;
    ux_nxt = ux_i;
    uy_nxt = uy_i;
    if ({2'b00, rx_i} >= trx) begin
      rx_nxt = QB'({2'b00, rx_i} - trx);
      ux_nxt = ux_i | (RB'(1) << J);
    end
    if ({2'b00, ry_i} >= try_) begin
      ry_nxt = QB'({2'b00, ry_i} - try_);
      uy_nxt = uy_i | (RB'(1) << J);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      rx_o   <= rx_nxt;
      ry_o   <= ry_nxt;
      ux_o   <= ux_nxt;
      uy_o   <= uy_nxt;
    end
  end

endmodule

// ===== sv/light_bar_axis_extraction_unit.sv =====
`timescale 1ns / 1ps
// light bar axis extraction, top level
// pipeline: lbax_front, the lbax_div_cell chain, the lbax_root_cell chain and an output register
// the root chain takes QB-bit quotients and gives RB-bit units (QB = bits of (DIR_SCALE*256)^2, RB = (QB+1)/2)
// throughput: one transfer per cycle; the whole pipeline holds while a result is stalled
// reset: synchronous active-low rst_n clears all valid bits, payload is not reset
// depends on lbax_pkg, lbax_front, lbax_div_cell, lbax_root_cell
module light_bar_axis_extraction_unit import lbax_pkg::*; #(
  parameter int DIR_SCALE  = DIR_SCALE_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_corner0_x,
  input  logic signed [COORD_BITS-1:0] in_corner0_y,
  input  logic signed [COORD_BITS-1:0] in_corner1_x,
  input  logic signed [COORD_BITS-1:0] in_corner1_y,
  input  logic signed [COORD_BITS-1:0] in_corner2_x,
  input  logic signed [COORD_BITS-1:0] in_corner2_y,
  input  logic signed [COORD_BITS-1:0] in_corner3_x,
  input  logic signed [COORD_BITS-1:0] in_corner3_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_end_a_x,
  output logic signed [COORD_BITS-1:0] out_end_a_y,
  output logic signed [COORD_BITS-1:0] out_end_b_x,
  output logic signed [COORD_BITS-1:0] out_end_b_y,
  output logic signed [COORD_BITS-1:0] out_mid_x,
  output logic signed [COORD_BITS-1:0] out_mid_y,
  output logic [LEN_W-1:0]             out_axis_length,
  output logic signed [UNIT_W-1:0]     out_unit_x,
  output logic signed [UNIT_W-1:0]     out_unit_y,
  output logic                         out_degenerate
);

  localparam int C    = COORD_BITS;
  localparam int QB   = $clog2((DIR_SCALE * 256) * (DIR_SCALE * 256) + 1);
  localparam int RB   = (QB + 1) / 2;
  localparam int LW   = 2 * C + 1;
  localparam int LB   = C + 1;
  localparam int DW   = LW + QB;
  localparam int PW   = 6 * C + 3;
  localparam int PW2  = PW + LB;
  localparam int NDIV = (QB > LB) ? QB : LB;
  localparam int LCW  = (LB > LEN_W) ? LB : LEN_W;

  logic out_valid_r;
  logic en;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign out_valid = out_valid_r;

  logic          dv    [NDIV+1];
  logic [PW-1:0] dside [NDIV+1];
  logic [LW-1:0] dd2   [NDIV+1];
  logic [DW-1:0] drx   [NDIV+1];
  logic [DW-1:0] dry   [NDIV+1];
  logic [QB-1:0] dqx   [NDIV+1];
  logic [QB-1:0] dqy   [NDIV+1];
  logic [LW-1:0] dlr   [NDIV+1];
  logic [LB-1:0] dlres [NDIV+1];

  lbax_front #(.C(C), .DS(DIR_SCALE), .QB(QB), .LW(LW), .DW(DW), .PW(PW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_valid (in_valid),
    .c0x    (in_corner0_x), .c0y (in_corner0_y),
    .c1x    (in_corner1_x), .c1y (in_corner1_y),
    .c2x    (in_corner2_x), .c2y (in_corner2_y),
    .c3x    (in_corner3_x), .c3y (in_corner3_y),
    .v_o    (dv[0]),
    .side_o (dside[0]),
    .d2_o   (dd2[0]),
    .nx_o   (drx[0]),
    .ny_o   (dry[0])
  );

  assign dqx[0]   = '0;
  assign dqy[0]   = '0;
  assign dlr[0]   = dd2[0];
  assign dlres[0] = '0;

  // divide and length root share the chain, each cell settles bit NDIV-1-k
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    lbax_div_cell #(
      .QB(QB), .LW(LW), .LB(LB), .DW(DW), .PW(PW), .J(NDIV - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv[k]),     .side_i (dside[k]),   .d2_i (dd2[k]),
      .rx_i   (drx[k]),    .ry_i   (dry[k]),
      .qx_i   (dqx[k]),    .qy_i   (dqy[k]),
      .lr_i   (dlr[k]),    .lres_i (dlres[k]),
      .v_o    (dv[k+1]),   .side_o (dside[k+1]), .d2_o (dd2[k+1]),
      .rx_o   (drx[k+1]),  .ry_o   (dry[k+1]),
      .qx_o   (dqx[k+1]),  .qy_o   (dqy[k+1]),
      .lr_o   (dlr[k+1]),  .lres_o (dlres[k+1])
    );
  end

  logic           rv    [RB+1];
  logic [PW2-1:0] rside [RB+1];
  logic [QB-1:0]  rrx   [RB+1];
  logic [QB-1:0]  rry   [RB+1];
  logic [RB-1:0]  rux   [RB+1];
  logic [RB-1:0]  ruy   [RB+1];

  assign rv[0]    = dv[NDIV];
  assign rside[0] = {dlres[NDIV], dside[NDIV]};
  assign rrx[0]   = dqx[NDIV];
  assign rry[0]   = dqy[NDIV];
  assign rux[0]   = '0;
  assign ruy[0]   = '0;

  for (genvar k = 0; k < RB; k++) begin : g_root
    lbax_root_cell #(.QB(QB), .RB(RB), .PW(PW2), .J(RB - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (rv[k]),   .side_i (rside[k]),
      .rx_i   (rrx[k]),  .ry_i   (rry[k]),
      .ux_i   (rux[k]),  .uy_i   (ruy[k]),
      .v_o    (rv[k+1]), .side_o (rside[k+1]),
      .rx_o   (rrx[k+1]), .ry_o  (rry[k+1]),
      .ux_o   (rux[k+1]), .uy_o  (ruy[k+1])
    );
  end

  logic [PW2-1:0]   fin;
  logic             degen;
  logic [LCW-1:0]   len_full;
  logic [UNIT_W-1:0] magx, magy;

  always_comb begin
    fin      = rside[RB];
    degen    = fin[6*C+2];
    len_full = LCW'(fin[PW2-1:PW]);
    magx     = UNIT_W'(rux[RB]);
    magy     = UNIT_W'(ruy[RB]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rv[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_end_a_x <= fin[C-1:0];
      out_end_a_y <= fin[2*C-1:C];
      out_end_b_x <= fin[3*C-1:2*C];
      out_end_b_y <= fin[4*C-1:3*C];
      out_mid_x   <= fin[5*C-1:4*C];
      out_mid_y   <= fin[6*C-1:5*C];
      out_axis_length <= (len_full > LCW'(LEN_MAX)) ? LEN_MAX : len_full[LEN_W-1:0];
      out_degenerate  <= degen;
      if (degen) begin
        out_unit_x <= '0;
        out_unit_y <= '0;
      end else begin
        out_unit_x <= fin[6*C] ? -magx : magx;
        out_unit_y <= fin[6*C+1] ? -magy : magy;
      end
    end
  end

endmodule
